// ===== hdl/rcp_pkg.sv =====
// ---------------------------------------------------------------------------
// rcp_pkg
// Shared types and codes for the control-packet compound parser.
// ---------------------------------------------------------------------------
package rcp_pkg;

  typedef enum logic [9:0] {
    PH_HDR   = 10'b00_0000_0001,
    PH_SR    = 10'b00_0000_0010,
    PH_RR    = 10'b00_0000_0100,
    PH_SSRC  = 10'b00_0000_1000,
    PH_TYPE  = 10'b00_0001_0000,
    PH_LEN   = 10'b00_0010_0000,
    PH_DATA  = 10'b00_0100_0000,
    PH_ALIGN = 10'b00_1000_0000,
    PH_DONE  = 10'b01_0000_0000,
    PH_UNK   = 10'b10_0000_0000
  } phase_t;

  localparam logic [2:0] KIND_FIELD = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_PKT   = 3'd2;
  localparam logic [2:0] KIND_ERR   = 3'd3;
  localparam logic [2:0] KIND_CMP   = 3'd4;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TRUNC   = 3'd1;
  localparam logic [2:0] ERR_VERSION = 3'd2;
  localparam logic [2:0] ERR_LENGTH  = 3'd3;
  localparam logic [2:0] ERR_PADNF   = 3'd4;
  localparam logic [2:0] ERR_PADLEN  = 3'd5;
  localparam logic [2:0] ERR_REPORT  = 3'd6;
  localparam logic [2:0] ERR_SDES    = 3'd7;

  localparam logic [3:0] FC_SSRC   = 4'd0;
  localparam logic [3:0] FC_NTP    = 4'd1;
  localparam logic [3:0] FC_RTPTS  = 4'd2;
  localparam logic [3:0] FC_PKTS   = 4'd3;
  localparam logic [3:0] FC_OCTETS = 4'd4;
  localparam logic [3:0] FC_BSSRC  = 4'd5;
  localparam logic [3:0] FC_FRAC   = 4'd6;
  localparam logic [3:0] FC_CUM    = 4'd7;
  localparam logic [3:0] FC_HSEQ   = 4'd8;
  localparam logic [3:0] FC_JIT    = 4'd9;
  localparam logic [3:0] FC_LSR    = 4'd10;
  localparam logic [3:0] FC_DLSR   = 4'd11;
  localparam logic [3:0] FC_CSSRC  = 4'd12;
  localparam logic [3:0] FC_CNAME  = 4'd13;

  localparam logic [7:0] PT_SR   = 8'd200;
  localparam logic [7:0] PT_RR   = 8'd201;
  localparam logic [7:0] PT_SDES = 8'd202;
  localparam logic [7:0] SDES_CNAME = 8'd1;

  typedef struct packed {
    logic        last;
    logic [2:0]  err;
    logic [63:0] value;
    logic [4:0]  idx;
    logic [3:0]  code;
    logic [4:0]  count;
    logic [7:0]  ptype;
    logic [2:0]  kind;
  } res_t;

  typedef struct packed {
    logic [1:0]      n;
    res_t [2:0]      res;
  } res_group_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] ptype, logic [4:0] count,
                                  logic [3:0] code, logic [4:0] idx, logic [63:0] value,
                                  logic [2:0] err, logic last);
    res_t r;
    r.kind = kind;
    r.ptype = ptype;
    r.count = count;
    r.code = code;
    r.idx = idx;
    r.value = value;
    r.err = err;
    r.last = last;
    return r;
  endfunction

endpackage

// ===== hdl/rcp_parse.sv =====
// ---------------------------------------------------------------------------
// rcp_parse
// Per-byte parse state and result generation, up to three results an item.
// ---------------------------------------------------------------------------
module rcp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_take,
  input  logic [7:0]            in_byte,
  input  logic                  in_eoc,
  output rcp_pkg::res_group_t   out_grp
);

  rcp_pkg::phase_t phase, phase_next;
  logic [17:0] boff, boff_next;
  logic [17:0] plen, plen_next;
  logic [7:0]  ctype, ctype_next;
  logic [4:0]  ccount, ccount_next;
  logic        pflag, pflag_next;
  logic [63:0] sh, sh_next;
  logic [2:0]  fbc, fbc_next;
  logic [4:0]  blk, blk_next;
  logic [7:0]  ibl, ibl_next;
  logic        cname, cname_next;
  logic [1:0]  csl, csl_next;
  logic [18:0] sfp, sfp_next;
  logic        serr, serr_next;
  logic [7:0]  prev, prev_next;
  logic        failed, failed_next;
  logic [4:0]  rpos, rpos_next;
  logic [5:0]  rblk, rblk_next;

  always_comb begin
    logic        stop;
    logic        clr;
    logic [1:0]  n;
    logic [17:0] o;
    logic [31:0] hdr;
    logic [17:0] fixed;
    logic        hit;
    logic [3:0]  code;
    logic [3:0]  len;
    logic [4:0]  idx;
    logic [63:0] v;
    logic [18:0] o1;
    logic [7:0]  pad;
    logic [18:0] size;
    logic [18:0] pay_end;
    logic [18:0] rep_size;
    rcp_pkg::res_t [2:0] res;

    phase_next = phase;   boff_next = boff;   plen_next = plen;
    ctype_next = ctype;   ccount_next = ccount; pflag_next = pflag;
    sh_next = sh;         fbc_next = fbc;     blk_next = blk;
    ibl_next = ibl;       cname_next = cname; csl_next = csl;
    sfp_next = sfp;       serr_next = serr;   prev_next = prev;
    failed_next = failed; rpos_next = rpos;   rblk_next = rblk;
    stop = 1'b0;
    clr = 1'b0;
    n = 2'd0;
    o = boff;
    o1 = {1'b0, boff} + 19'd1;
    hdr = '0;
    fixed = '0;
    hit = 1'b0;
    code = '0;
    len = 4'd4;
    idx = '0;
    v = '0;
    pad = '0;
    size = '0;
    pay_end = '0;
    rep_size = '0;
    res = '0;

    if (failed) begin
      clr = in_eoc;
    end else begin
      sh_next = {sh[55:0], in_byte};
      if (o < 18'd3) begin
        if (o == 18'd0) begin
          pflag_next = in_byte[5];
          ccount_next = in_byte[4:0];
        end else if (o == 18'd1) begin
          ctype_next = in_byte;
        end
        if (in_eoc) begin
          res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, ctype_next, ccount_next, '0, '0, '0,
                                   rcp_pkg::ERR_TRUNC, 1'b1);
          n = n + 2'd1;
          clr = 1'b1;
        end else begin
          boff_next = o + 18'd1;
        end
      end else begin
        if (o == 18'd3) begin
          hdr = sh_next[31:0];
          if (hdr[31:30] != 2'd2) begin
            res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, ctype_next, ccount_next, '0, '0, '0,
                                     rcp_pkg::ERR_VERSION, 1'b1);
            n = n + 2'd1;
            stop = 1'b1;
          end else begin
            plen_next = {hdr[15:0], 2'b11};
            blk_next = '0;
            fbc_next = '0;
            cname_next = 1'b0;
            serr_next = 1'b0;
            csl_next = '0;
            sfp_next = '0;
            rpos_next = '0;
            rblk_next = '0;
            if (ctype_next == rcp_pkg::PT_SR) begin
              phase_next = rcp_pkg::PH_SR;
            end else if (ctype_next == rcp_pkg::PT_RR) begin
              phase_next = rcp_pkg::PH_RR;
            end else if (ctype_next == rcp_pkg::PT_SDES) begin
              phase_next = (ccount_next != 5'd0) ? rcp_pkg::PH_SSRC : rcp_pkg::PH_DONE;
              sfp_next = 19'd4;
            end else begin
              phase_next = rcp_pkg::PH_UNK;
            end
          end
        end

        if (!stop && in_eoc && o != plen_next) begin
          res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, ctype_next, ccount_next, '0, '0, '0,
                                   rcp_pkg::ERR_LENGTH, 1'b1);
          n = n + 2'd1;
          stop = 1'b1;
        end

        if (!stop && o > 18'd3) begin
          if (phase == rcp_pkg::PH_SR || phase == rcp_pkg::PH_RR) begin
            fixed = (phase == rcp_pkg::PH_SR) ? 18'd28 : 18'd8;
            if (o < fixed) begin
              case (o[4:0])
                5'd7:  begin hit = 1'b1; code = rcp_pkg::FC_SSRC;   end
                5'd15: begin hit = 1'b1; code = rcp_pkg::FC_NTP; len = 4'd8; end
                5'd19: begin hit = 1'b1; code = rcp_pkg::FC_RTPTS;  end
                5'd23: begin hit = 1'b1; code = rcp_pkg::FC_PKTS;   end
                5'd27: begin hit = 1'b1; code = rcp_pkg::FC_OCTETS; end
                default: hit = 1'b0;
              endcase
            end else begin
              rpos_next = (rpos == 5'd23) ? 5'd0 : rpos + 5'd1;
              if (rpos == 5'd23 && rblk != 6'd32) rblk_next = rblk + 6'd1;
              idx = rblk[4:0];
              if (rblk < {1'b0, ccount}) begin
                case (rpos)
                  5'd3:  begin hit = 1'b1; code = rcp_pkg::FC_BSSRC; end
                  5'd4:  begin hit = 1'b1; code = rcp_pkg::FC_FRAC; len = 4'd1; end
                  5'd7:  begin hit = 1'b1; code = rcp_pkg::FC_CUM;  len = 4'd3; end
                  5'd11: begin hit = 1'b1; code = rcp_pkg::FC_HSEQ; end
                  5'd15: begin hit = 1'b1; code = rcp_pkg::FC_JIT;  end
                  5'd19: begin hit = 1'b1; code = rcp_pkg::FC_LSR;  end
                  5'd23: begin hit = 1'b1; code = rcp_pkg::FC_DLSR; end
                  default: hit = 1'b0;
                endcase
              end
            end
            if (hit) begin
              case (len)
                4'd1: v = {56'd0, sh_next[7:0]};
                4'd3: v = {{40{sh_next[23]}}, sh_next[23:0]};
                4'd8: v = sh_next;
                default: v = {32'd0, sh_next[31:0]};
              endcase
              if (code != rcp_pkg::FC_CUM && len == 4'd3) v = {40'd0, sh_next[23:0]};
              res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_FIELD, ctype_next, ccount_next, code,
                                       idx, v, rcp_pkg::ERR_NONE, 1'b0);
              n = n + 2'd1;
            end
          end else if (phase == rcp_pkg::PH_UNK) begin
            res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_DATA, ctype_next, ccount_next, '0, '0,
                                     {56'd0, in_byte}, rcp_pkg::ERR_NONE, 1'b0);
            n = n + 2'd1;
          end else begin
            case (phase)
              rcp_pkg::PH_SSRC: begin
                fbc_next = fbc + 3'd1;
                if (fbc_next >= 3'd4) begin
                  res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_FIELD, ctype_next, ccount_next,
                                           rcp_pkg::FC_CSSRC, blk, {32'd0, sh_next[31:0]},
                                           rcp_pkg::ERR_NONE, 1'b0);
                  n = n + 2'd1;
                  fbc_next = '0;
                  cname_next = 1'b0;
                  phase_next = rcp_pkg::PH_TYPE;
                end
              end
              rcp_pkg::PH_TYPE: begin
                if (in_byte == 8'd0) begin
                  if (!cname) begin
                    serr_next = 1'b1;
                    phase_next = rcp_pkg::PH_DONE;
                  end else if (o1[1:0] == csl) begin
                    blk_next = blk + 5'd1;
                    if (blk_next == ccount) begin
                      phase_next = rcp_pkg::PH_DONE;
                      sfp_next = o1;
                    end else begin
                      phase_next = rcp_pkg::PH_SSRC;
                      csl_next = o1[1:0];
                      fbc_next = '0;
                    end
                  end else begin
                    phase_next = rcp_pkg::PH_ALIGN;
                  end
                end else begin
                  prev_next = in_byte;
                  phase_next = rcp_pkg::PH_LEN;
                end
              end
              rcp_pkg::PH_LEN: begin
                if (prev == rcp_pkg::SDES_CNAME && (cname || in_byte == 8'd0)) begin
                  serr_next = 1'b1;
                  phase_next = rcp_pkg::PH_DONE;
                end else begin
                  if (prev == rcp_pkg::SDES_CNAME) begin
                    res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_FIELD, ctype_next, ccount_next,
                                             rcp_pkg::FC_CNAME, blk, {56'd0, in_byte},
                                             rcp_pkg::ERR_NONE, 1'b0);
                    n = n + 2'd1;
                    cname_next = 1'b1;
                  end
                  ibl_next = in_byte;
                  phase_next = (in_byte != 8'd0) ? rcp_pkg::PH_DATA : rcp_pkg::PH_TYPE;
                end
              end
              rcp_pkg::PH_DATA: begin
                if (prev == rcp_pkg::SDES_CNAME) begin
                  res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_DATA, ctype_next, ccount_next, '0,
                                           blk, {56'd0, in_byte}, rcp_pkg::ERR_NONE, 1'b0);
                  n = n + 2'd1;
                end
                ibl_next = ibl - 8'd1;
                if (ibl_next == 8'd0) phase_next = rcp_pkg::PH_TYPE;
              end
              rcp_pkg::PH_ALIGN: begin
                if (in_byte != 8'd0) begin
                  serr_next = 1'b1;
                  phase_next = rcp_pkg::PH_DONE;
                end else if (o1[1:0] == csl) begin
                  blk_next = blk + 5'd1;
                  if (blk_next == ccount) begin
                    phase_next = rcp_pkg::PH_DONE;
                    sfp_next = o1;
                  end else begin
                    phase_next = rcp_pkg::PH_SSRC;
                    csl_next = o1[1:0];
                    fbc_next = '0;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        if (!stop) begin
          if (o != plen_next) begin
            boff_next = o + 18'd1;
          end else begin
            pad = pflag_next ? in_byte : 8'd0;
            size = {1'b0, plen_next} + 19'd1;
            pay_end = size - {11'd0, pad};
            rep_size = ((phase_next == rcp_pkg::PH_SR) ? 19'd28 : 19'd8)
                       + 19'd24 * {14'd0, ccount_next};
            if (pflag_next && !in_eoc) begin
              res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, ctype_next, ccount_next, '0, '0,
                                       '0, rcp_pkg::ERR_PADNF, 1'b1);
              n = n + 2'd1;
              stop = 1'b1;
            end else if (pflag_next && (pad == 8'd0 || {11'd0, pad} > size - 19'd4)) begin
              res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, ctype_next, ccount_next, '0, '0,
                                       '0, rcp_pkg::ERR_PADLEN, 1'b1);
              n = n + 2'd1;
              stop = 1'b1;
            end else if ((phase_next == rcp_pkg::PH_SR || phase_next == rcp_pkg::PH_RR)
                         && pay_end != rep_size) begin
              res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, ctype_next, ccount_next, '0, '0,
                                       '0, rcp_pkg::ERR_REPORT, 1'b1);
              n = n + 2'd1;
              stop = 1'b1;
            end else if (phase_next != rcp_pkg::PH_SR && phase_next != rcp_pkg::PH_RR
                         && phase_next != rcp_pkg::PH_UNK
                         && (serr_next || phase_next != rcp_pkg::PH_DONE
                             || sfp_next != pay_end)) begin
              res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_ERR, ctype_next, ccount_next, '0, '0,
                                       '0, rcp_pkg::ERR_SDES, 1'b1);
              n = n + 2'd1;
              stop = 1'b1;
            end else begin
              res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_PKT, ctype_next, ccount_next, '0, '0,
                                       {56'd0, pad}, rcp_pkg::ERR_NONE, 1'b0);
              n = n + 2'd1;
              if (in_eoc) begin
                res[n] = rcp_pkg::mk_res(rcp_pkg::KIND_CMP, ctype_next, ccount_next, '0, '0,
                                         '0, rcp_pkg::ERR_NONE, 1'b1);
                n = n + 2'd1;
              end
              clr = 1'b1;
            end
          end
        end
        if (stop) begin
          if (in_eoc) clr = 1'b1;
          else failed_next = 1'b1;
        end
      end
    end

    if (clr) begin
      phase_next = rcp_pkg::PH_HDR; boff_next = '0; plen_next = '0;
      ctype_next = '0; ccount_next = '0; pflag_next = 1'b0;
      sh_next = '0; fbc_next = '0; blk_next = '0; ibl_next = '0;
      cname_next = 1'b0; csl_next = '0; sfp_next = '0; serr_next = 1'b0;
      prev_next = '0; failed_next = 1'b0; rpos_next = '0; rblk_next = '0;
    end

    out_grp.n = in_take ? n : 2'd0;
    out_grp.res = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rcp_pkg::PH_HDR; boff <= '0; plen <= '0;
      ctype <= '0; ccount <= '0; pflag <= 1'b0;
      sh <= '0; fbc <= '0; blk <= '0; ibl <= '0;
      cname <= 1'b0; csl <= '0; sfp <= '0; serr <= 1'b0;
      prev <= '0; failed <= 1'b0; rpos <= '0; rblk <= '0;
    end else if (in_take) begin
      phase <= phase_next; boff <= boff_next; plen <= plen_next;
      ctype <= ctype_next; ccount <= ccount_next; pflag <= pflag_next;
      sh <= sh_next; fbc <= fbc_next; blk <= blk_next; ibl <= ibl_next;
      cname <= cname_next; csl <= csl_next; sfp <= sfp_next; serr <= serr_next;
      prev <= prev_next; failed <= failed_next; rpos <= rpos_next; rblk <= rblk_next;
    end
  end

endmodule

// ===== hdl/rtcp_compound_parser_core.sv =====
// ---------------------------------------------------------------------------
// rtcp_compound_parser_core
// Compound control-packet parser: one byte in, fields and status out.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                         tuser  tlast
//  s_axis   in   in_byte                       -      end_of_compound
//  m_axis   out  type,count,code,index,value,  kind   last
//                error
// An accepted byte is parsed in the cycle it is taken and its zero to three
// results enter a four-entry result queue; one result leaves per cycle while
// m_tready is high. A byte is taken each cycle while the queue holds at most one
// result, so with m_tready high a stream yielding one result a byte or fewer runs
// at one byte a cycle. Synchronous reset clears the parse state and the queue.
// ---------------------------------------------------------------------------
module rtcp_compound_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // pkt_type, packet_count, field_code, block_index,
                                 // field_value, error_code, zero fill
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast
);

  rcp_pkg::res_group_t grp;
  rcp_pkg::res_t q [4];
  logic [1:0] rd, wr;
  logic [2:0] cnt;
  logic take, pop;
  rcp_pkg::res_t head;

  assign s_tready = (cnt <= 3'd1);
  assign take = s_tvalid && s_tready;
  assign pop = m_tvalid && m_tready;

  rcp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_take (take),
    .in_byte (s_tdata),
    .in_eoc  (s_tlast),
    .out_grp (grp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
      wr <= '0;
      cnt <= '0;
    end else begin
      rd <= rd + {1'b0, pop};
      wr <= wr + grp.n;
      cnt <= cnt + {1'b0, grp.n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (grp.n > 2'd0) q[wr] <= grp.res[0];
    if (grp.n > 2'd1) q[wr + 2'd1] <= grp.res[1];
    if (grp.n > 2'd2) q[wr + 2'd2] <= grp.res[2];
  end

  assign head = q[rd];
  assign m_tvalid = (cnt != 3'd0);
  assign m_tuser = head.kind;
  assign m_tlast = head.last;
  assign m_tdata = {7'd0, head.err, head.value, head.idx, head.code, head.count, head.ptype};

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue overflow");
  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !take |-> grp.n == 2'd0)
    else $error("results without an accepted item");
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    take |=> cnt <= 3'd4 && m_tvalid == (cnt != 3'd0))
    else $error("queue accounting broken");

endmodule

// ===== tb/tb_rtcp_compound_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_rtcp_compound_parser_core
// Self-checking bench for the compound control-packet parser. Builds
// compounds of sender reports, receiver reports, source descriptions and
// unknown packets, well formed and damaged. Predicts every result byte by
// byte and checks each output item in order under random idling and stalls.
// ---------------------------------------------------------------------------
module tb_rtcp_compound_parser_core;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  rtcp_compound_parser_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #2 clk = ~clk;

  rcp_pkg::res_t expected_q[$];
  logic [7:0]  frame_q[$];
  logic [7:0]  body_q[$];
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_len = 0;
  int          hold_cnt = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          compounds_sent = 0;
  int          errors_seen = 0;

  // parser state mirror
  rcp_pkg::phase_t ph;
  logic [31:0] pos, plen, finish_pt;
  logic [7:0]  cur_type, sdes_item, item_left;
  logic [4:0]  cur_count, block_cnt;
  logic [63:0] shreg;
  logic [1:0]  chunk_low;
  int          fbc;
  logic        pad_flag, cname_seen, sdes_err, failed;

  task automatic clear_state();
    ph = rcp_pkg::PH_HDR; pos = 0; plen = 0; cur_type = 0; cur_count = 0; pad_flag = 0;
    shreg = 0; fbc = 0; block_cnt = 0; item_left = 0; cname_seen = 0;
    chunk_low = 0; finish_pt = 0; sdes_err = 0; sdes_item = 0; failed = 0;
  endtask

  task automatic push_result(logic [2:0] kind, logic [3:0] code, logic [4:0] idx,
                             logic [63:0] value, logic [2:0] err, logic last);
    rcp_pkg::res_t r;
    r.kind = kind; r.ptype = cur_type; r.count = cur_count; r.code = code;
    r.idx = idx; r.value = value; r.err = err; r.last = last;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic raise_error(logic [2:0] err, logic eoc);
    push_result(rcp_pkg::KIND_ERR, rcp_pkg::FC_SSRC, 5'd0, 64'd0, err, 1'b1);
    if (eoc) clear_state();
    else failed = 1'b1;
  endtask

  function automatic bit report_slot(logic [31:0] o, logic [31:0] fixed,
                                     output logic [3:0] code, output int len,
                                     output logic [4:0] idx);
    logic [31:0] r, k, p;
    idx = 0;
    len = 4;
    code = rcp_pkg::FC_SSRC;
    if (o < fixed) begin
      case (o)
        7:  begin code = rcp_pkg::FC_SSRC; return 1; end
        15: begin code = rcp_pkg::FC_NTP; len = 8; return 1; end
        19: begin code = rcp_pkg::FC_RTPTS; return 1; end
        23: begin code = rcp_pkg::FC_PKTS; return 1; end
        27: begin code = rcp_pkg::FC_OCTETS; return 1; end
        default: return 0;
      endcase
    end
    r = o - fixed;
    k = r / 24;
    p = r % 24;
    if (k >= cur_count) return 0;
    idx = k[4:0];
    case (p)
      3:  begin code = rcp_pkg::FC_BSSRC; return 1; end
      4:  begin code = rcp_pkg::FC_FRAC; len = 1; return 1; end
      7:  begin code = rcp_pkg::FC_CUM; len = 3; return 1; end
      11: begin code = rcp_pkg::FC_HSEQ; return 1; end
      15: begin code = rcp_pkg::FC_JIT; return 1; end
      19: begin code = rcp_pkg::FC_LSR; return 1; end
      23: begin code = rcp_pkg::FC_DLSR; return 1; end
      default: return 0;
    endcase
  endfunction

  task automatic chunk_finish(logic [31:0] nxt);
    block_cnt = block_cnt + 5'd1;
    if (block_cnt == cur_count) begin
      ph = rcp_pkg::PH_DONE;
      finish_pt = nxt;
    end else begin
      ph = rcp_pkg::PH_SSRC;
      chunk_low = nxt[1:0];
      fbc = 0;
    end
  endtask

  task automatic sdes_fault();
    sdes_err = 1'b1;
    ph = rcp_pkg::PH_DONE;
  endtask

  task automatic sdes_step(logic [7:0] b, logic [31:0] o);
    case (ph)
      rcp_pkg::PH_SSRC: begin
        fbc++;
        if (fbc >= 4) begin
          push_result(rcp_pkg::KIND_FIELD, rcp_pkg::FC_CSSRC, block_cnt,
                      {32'd0, shreg[31:0]}, rcp_pkg::ERR_NONE, 1'b0);
          fbc = 0;
          cname_seen = 0;
          ph = rcp_pkg::PH_TYPE;
        end
      end
      rcp_pkg::PH_TYPE: begin
        if (b == 0) begin
          if (!cname_seen) sdes_fault();
          else if (((o + 1) & 3) == chunk_low) chunk_finish(o + 1);
          else ph = rcp_pkg::PH_ALIGN;
        end else begin
          sdes_item = b;
          ph = rcp_pkg::PH_LEN;
        end
      end
      rcp_pkg::PH_LEN: begin
        if (sdes_item == rcp_pkg::SDES_CNAME && (cname_seen || b == 0)) begin
          sdes_fault();
        end else begin
          if (sdes_item == rcp_pkg::SDES_CNAME) begin
            push_result(rcp_pkg::KIND_FIELD, rcp_pkg::FC_CNAME, block_cnt, {56'd0, b},
                        rcp_pkg::ERR_NONE, 1'b0);
            cname_seen = 1;
          end
          item_left = b;
          ph = (b != 0) ? rcp_pkg::PH_DATA : rcp_pkg::PH_TYPE;
        end
      end
      rcp_pkg::PH_DATA: begin
        if (sdes_item == rcp_pkg::SDES_CNAME)
          push_result(rcp_pkg::KIND_DATA, rcp_pkg::FC_SSRC, block_cnt, {56'd0, b},
                      rcp_pkg::ERR_NONE, 1'b0);
        item_left = item_left - 8'd1;
        if (item_left == 0) ph = rcp_pkg::PH_TYPE;
      end
      rcp_pkg::PH_ALIGN: begin
        if (b != 0) sdes_fault();
        else if (((o + 1) & 3) == chunk_low) chunk_finish(o + 1);
      end
      default: ;
    endcase
  endtask

  task automatic take_byte(logic [7:0] b, logic eoc);
    logic [31:0] o, hdr, pad, size, pay_end, fixed;
    logic [3:0]  code;
    logic [4:0]  idx;
    logic [63:0] v;
    int          len;
    o = pos;
    if (failed) begin
      if (eoc) clear_state();
      return;
    end
    shreg = {shreg[55:0], b};
    if (o < 3) begin
      if (o == 0) begin
        pad_flag = b[5];
        cur_count = b[4:0];
      end else if (o == 1) begin
        cur_type = b;
      end
      if (eoc) begin
        raise_error(rcp_pkg::ERR_TRUNC, eoc);
        return;
      end
      pos = o + 1;
      return;
    end
    if (o == 3) begin
      hdr = shreg[31:0];
      if (hdr[31:30] != 2'd2) begin
        raise_error(rcp_pkg::ERR_VERSION, eoc);
        return;
      end
      plen = ({16'd0, hdr[15:0]} + 1) * 4 - 1;
      block_cnt = 0; fbc = 0; cname_seen = 0; sdes_err = 0; chunk_low = 0; finish_pt = 0;
      if (cur_type == rcp_pkg::PT_SR) ph = rcp_pkg::PH_SR;
      else if (cur_type == rcp_pkg::PT_RR) ph = rcp_pkg::PH_RR;
      else if (cur_type == rcp_pkg::PT_SDES) begin
        ph = (cur_count != 0) ? rcp_pkg::PH_SSRC : rcp_pkg::PH_DONE;
        finish_pt = 4;
      end else ph = rcp_pkg::PH_UNK;
    end
    if (eoc && o != plen) begin
      raise_error(rcp_pkg::ERR_LENGTH, eoc);
      return;
    end
    fixed = (ph == rcp_pkg::PH_SR) ? 28 : 8;
    if (o > 3) begin
      if (ph == rcp_pkg::PH_SR || ph == rcp_pkg::PH_RR) begin
        if (report_slot(o, fixed, code, len, idx)) begin
          v = shreg;
          if (len < 8) v &= (64'd1 << (8 * len)) - 1;
          if (code == rcp_pkg::FC_CUM && v[23]) v |= ~64'hff_ffff;
          push_result(rcp_pkg::KIND_FIELD, code, idx, v, rcp_pkg::ERR_NONE, 1'b0);
        end
      end else if (ph == rcp_pkg::PH_UNK) begin
        push_result(rcp_pkg::KIND_DATA, rcp_pkg::FC_SSRC, 5'd0, {56'd0, b},
                    rcp_pkg::ERR_NONE, 1'b0);
      end else begin
        sdes_step(b, o);
      end
    end
    if (o != plen) begin
      pos = o + 1;
      return;
    end
    pad = pad_flag ? {24'd0, b} : 0;
    size = plen + 1;
    if (pad_flag && !eoc) begin
      raise_error(rcp_pkg::ERR_PADNF, eoc);
      return;
    end
    if (pad_flag && (pad == 0 || pad > size - 4)) begin
      raise_error(rcp_pkg::ERR_PADLEN, eoc);
      return;
    end
    pay_end = size - pad;
    if (ph == rcp_pkg::PH_SR || ph == rcp_pkg::PH_RR) begin
      if (pay_end != fixed + 24 * cur_count) begin
        raise_error(rcp_pkg::ERR_REPORT, eoc);
        return;
      end
    end else if (ph != rcp_pkg::PH_UNK) begin
      if (sdes_err || ph != rcp_pkg::PH_DONE || finish_pt != pay_end) begin
        raise_error(rcp_pkg::ERR_SDES, eoc);
        return;
      end
    end
    push_result(rcp_pkg::KIND_PKT, rcp_pkg::FC_SSRC, 5'd0, {32'd0, pad},
                rcp_pkg::ERR_NONE, 1'b0);
    if (eoc) push_result(rcp_pkg::KIND_CMP, rcp_pkg::FC_SSRC, 5'd0, 64'd0,
                         rcp_pkg::ERR_NONE, 1'b1);
    clear_state();
  endtask

  // ---- compound builders ----
  task automatic put_frame(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  task automatic put_body(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  task automatic add_packet(logic [7:0] ptype, logic [4:0] count, int pad, int pad_val);
    int words;
    words = (body_q.size() + pad + 4) / 4 - 1;
    put_frame({2'b10, pad != 0, count});
    put_frame(ptype);
    put_frame(words[15:8]);
    put_frame(words[7:0]);
    foreach (body_q[i]) put_frame(body_q[i]);
    for (int i = 1; i < pad; i++) put_frame(8'h00);
    if (pad != 0) put_frame(pad_val[7:0]);
    body_q.delete();
  endtask

  task automatic add_random_body(int n);
    repeat (n) put_body(8'($urandom_range(255)));
  endtask

  task automatic add_report(logic is_sr, logic [4:0] count, int pad);
    add_random_body((is_sr ? 24 : 4) + 24 * count);
    add_packet(is_sr ? rcp_pkg::PT_SR : rcp_pkg::PT_RR, count, pad, pad);
  endtask

  task automatic add_sdes_chunk(logic with_cname);
    int start, l;
    start = body_q.size();
    add_random_body(4);
    if (with_cname) begin
      l = $urandom_range(1, 6);
      put_body(rcp_pkg::SDES_CNAME);
      put_body(8'(l));
      add_random_body(l);
    end
    if ($urandom_range(1)) begin
      l = $urandom_range(0, 3);
      put_body(8'($urandom_range(2, 8)));
      put_body(8'(l));
      add_random_body(l);
    end
    put_body(8'h00);
    while ((body_q.size() - start) % 4 != 0) put_body(8'h00);
  endtask

  task automatic add_sdes(int chunks, int pad);
    repeat (chunks) add_sdes_chunk(1'b1);
    add_packet(rcp_pkg::PT_SDES, 5'(chunks), pad, pad);
  endtask

  task automatic add_unknown(int words, int pad);
    logic [7:0] pt;
    do pt = 8'($urandom_range(255));
    while (pt == rcp_pkg::PT_SR || pt == rcp_pkg::PT_RR || pt == rcp_pkg::PT_SDES);
    add_random_body(4 * words);
    add_packet(pt, 5'($urandom_range(31)), pad, pad);
  endtask

  // ---- stimulus and drain ----
  task automatic send_compound();
    int gap;
    compounds_sent++;
    foreach (frame_q[i]) begin
      s_tvalid <= 1'b1;
      s_tdata  <= frame_q[i];
      s_tlast  <= (i == frame_q.size() - 1);
      do @(posedge clk); while (!s_tready);
      take_byte(frame_q[i], i == frame_q.size() - 1);
      bytes_sent++;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
      if (i == frame_q.size() - 1 || gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap > 0 ? gap : 1) @(posedge clk);
      end
    end
    frame_q.delete();
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                            logic [7:0] b3, int n);
    logic [7:0] v[4];
    v = '{b0, b1, b2, b3};
    for (int i = 0; i < n; i++) put_frame(v[i]);
    send_compound();
  endtask

  // ---- tests ----
  task automatic test_header_faults();
    send_bytes(8'hff, 8'hff, 8'h00, 8'h00, 2);
    send_bytes(8'h40, rcp_pkg::PT_SR, 8'h00, 8'h00, 4);
    send_bytes(8'h00, rcp_pkg::PT_RR, 8'h00, 8'h01, 4);
    send_bytes(8'hff, 8'h00, 8'h00, 8'h00, 1);
    send_bytes(8'h80, rcp_pkg::PT_RR, 8'h00, 8'h01, 4);
  endtask

  task automatic test_reports();
    add_report(1'b1, 5'd1, 0);
    frame_q[33] = 8'h80;
    frame_q[34] = 8'h00;
    frame_q[35] = 8'h01;
    send_compound();
    add_report(1'b0, 5'd0, 0);
    add_report(1'b0, 5'd1, 0);
    send_compound();
    add_random_body(4);
    add_packet(rcp_pkg::PT_RR, 5'd31, 0, 0);
    send_compound();
  endtask

  task automatic test_sdes();
    add_sdes(2, 0);
    send_compound();
    add_sdes_chunk(1'b0);
    add_packet(rcp_pkg::PT_SDES, 5'd1, 0, 0);
    send_compound();
    add_packet(rcp_pkg::PT_SDES, 5'd0, 0, 0);
    send_compound();
  endtask

  task automatic test_padding();
    add_unknown(1, 4);
    send_compound();
    add_report(1'b0, 5'd0, 4);
    add_unknown(0, 0);
    send_compound();
    add_unknown(1, 0);
    frame_q[0][5] = 1'b1;
    frame_q[$] = 8'h00;
    send_compound();
    add_unknown(1, 0);
    frame_q[0][5] = 1'b1;
    frame_q[$] = 8'hff;
    send_compound();
  endtask

  task automatic build_random_compound();
    int npk, sel, cut;
    npk = $urandom_range(1, 3);
    for (int p = 0; p < npk; p++) begin
      sel = $urandom_range(3);
      case (sel)
        0: add_report(1'b1, 5'($urandom_range(2)), 0);
        1: add_report(1'b0, 5'($urandom_range(2)), 0);
        2: add_sdes($urandom_range(1, 2), 0);
        default: add_unknown($urandom_range(3), 0);
      endcase
    end
    if ($urandom_range(99) < 30) begin
      add_unknown($urandom_range(2), 4);
    end
    if ($urandom_range(99) < 22) begin
      sel = $urandom_range(2);
      if (sel == 0) begin
        frame_q[$urandom_range(frame_q.size() - 1)] = 8'($urandom_range(255));
      end else if (sel == 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 12)) put_frame(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int byte_goal);
    int stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = bytes_sent + byte_goal;
    while (bytes_sent < stop_at) begin
      build_random_compound();
      send_compound();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len = 300;
    add_report(1'b0, 5'd1, 0);
    send_compound();
    wait_drained();
  endtask

  // ---- receiver and checker ----
  always @(posedge clk) begin
    if (hold_len > 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    rcp_pkg::res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.ptype = m_tdata[7:0];
      got.count = m_tdata[12:8];
      got.code  = m_tdata[16:13];
      got.idx   = m_tdata[21:17];
      got.value = m_tdata[85:22];
      got.err   = m_tdata[88:86];
      got.kind  = m_tuser;
      got.last  = m_tlast;
      results_seen++;
      if (got.kind == rcp_pkg::KIND_ERR) errors_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: kind %0d value %h", got.kind, got.value);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp k%0d pt%0d n%0d c%0d i%0d v%h e%0d l%0d, ",
                     want.kind, want.ptype, want.count, want.code, want.idx, want.value,
                     want.err, want.last,
                     "got k%0d pt%0d n%0d c%0d i%0d v%h e%0d l%0d",
                     got.kind, got.ptype, got.count, got.code, got.idx, got.value,
                     got.err, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rtcp_compound_parser_core regression: fail");
      $finish;
    end
  end

  initial begin
    clear_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_faults();
    test_reports();
    test_sdes();
    test_padding();
    wait_drained();
    test_backpressure();
    test_random(27, 61, 20);
    wait_drained();
    test_random(61, 27, 20);
    test_random(0, 0, 20);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d compounds, %0d bytes, %0d results (%0d error reports)",
             compounds_sent, bytes_sent, results_seen, errors_seen);
    $display("mismatches: %0d, results still pending: %0d", mismatches, expected_q.size());
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("rtcp_compound_parser_core regression: pass");
    end else begin
      $display("rtcp_compound_parser_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rcp_pkg.sv
hdl/rcp_parse.sv
hdl/rtcp_compound_parser_core.sv
tb/tb_rtcp_compound_parser_core.sv
